// ===== sv/a429tx_pkg.sv =====
// a429tx_pkg: shared types and codes for the arinc 429 word transmitter
// phase encoding, configuration register indexes and the result layout
// no dependencies
`default_nettype none

package a429tx_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_BITS = 2'd1,
        PH_GAP  = 2'd2
    } phase_t;

    // configuration register indexes (byte address is 4 * index)
    localparam logic [1:0] REG_SPEED_HIGH  = 2'd0;
    localparam logic [1:0] REG_HIGH_TICKS  = 2'd1;
    localparam logic [1:0] REG_LOW_TICKS   = 2'd2;

    localparam int unsigned TICK_W = 16;

    localparam logic       SPEED_HIGH_RST = 1'b1;
    localparam logic [15:0] HIGH_TICKS_RST = 16'd10;
    localparam logic [15:0] LOW_TICKS_RST  = 16'd80;

    localparam logic KIND_SEND = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // result word, line_a in the lowest bit
    typedef struct packed {
        logic word_done;
        logic rejected;
        logic busy_res;
        logic line_b;
        logic line_a;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/arinc429_word_transmitter.sv =====
// arinc429_word_transmitter: two-wire arinc 429 serializer with apb register port
// depends on a429tx_pkg
`default_nettype none

// Takes one word per clock on the s_ stream while s_tready is high: s_tuser = 1 is
// a time tick, s_tuser = 0 a request to send s_tdata. The result for each word (line
// levels, busy, rejected, word done) is computed in the same cycle from the registered
// transmit state and lands in the output register, or in the skid entry if m_ stalls.
// The sustained rate is one word per clock while m_tready is high; a two-entry output
// buffer keeps s_tready high while one result waits on m_tready. Bit period registers
// may only be written while no word is in flight. Send requests arriving while a word
// or its trailing gap is on the line, or carrying an all-zero word, are rejected.
module arinc429_word_transmitter #(
    parameter int unsigned WORD_BITS   = 32,
    parameter int unsigned GAP_PERIODS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [31:0] s_tdata,   // word[31:0]
    input  wire logic        s_tuser,   // kind

    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [7:0]  m_tdata,   // line_a, line_b, busy_res, rejected, word_done, 3 zero bits

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    localparam int unsigned BITS_W = $clog2(WORD_BITS);
    localparam int unsigned GAP_W  = $clog2(GAP_PERIODS + 1);
    localparam int unsigned TW     = a429tx_pkg::TICK_W;

    // configuration registers
    logic          speed_high_reg;
    logic [TW-1:0] high_ticks_reg;
    logic [TW-1:0] low_ticks_reg;

    // transmit state
    a429tx_pkg::phase_t   phase_reg, phase_next;
    logic [WORD_BITS-1:0] shift_reg, shift_next;
    logic [BITS_W-1:0]    bits_sent_reg, bits_sent_next;
    logic [TW-1:0]        tick_count_reg, tick_count_next;
    logic [GAP_W-1:0]     gap_reg, gap_next;
    logic                 level_a_reg, level_a_next;
    logic                 level_b_reg, level_b_next;

    // output buffer
    a429tx_pkg::result_t  out_reg, skid_reg, result;
    logic                 out_valid_reg, skid_valid_reg;

    logic                 push, pop;
    logic                 is_send, is_tick;
    logic [WORD_BITS-1:0] word_ext;
    logic                 word_zero;
    logic                 parity;
    logic [TW-1:0]        period;
    logic [TW-1:0]        tick_inc;
    logic                 tick_end;
    logic                 send_ok;
    logic                 last_bit;
    logic                 last_gap;

    // ---------------- configuration port ----------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_high_reg <= a429tx_pkg::SPEED_HIGH_RST;
            high_ticks_reg <= a429tx_pkg::HIGH_TICKS_RST;
            low_ticks_reg  <= a429tx_pkg::LOW_TICKS_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                a429tx_pkg::REG_SPEED_HIGH: speed_high_reg <= pwdata[0];
                a429tx_pkg::REG_HIGH_TICKS: high_ticks_reg <= pwdata[TW-1:0];
                a429tx_pkg::REG_LOW_TICKS:  low_ticks_reg  <= pwdata[TW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            a429tx_pkg::REG_SPEED_HIGH: prdata = {31'd0, speed_high_reg};
            a429tx_pkg::REG_HIGH_TICKS: prdata = {{(32-TW){1'b0}}, high_ticks_reg};
            a429tx_pkg::REG_LOW_TICKS:  prdata = {{(32-TW){1'b0}}, low_ticks_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // ---------------- shared terms ----------------
    assign push    = s_tvalid && s_tready;
    assign pop     = m_tvalid && m_tready;
    assign is_send = push && (s_tuser == a429tx_pkg::KIND_SEND);
    assign is_tick = push && (s_tuser == a429tx_pkg::KIND_TICK);

    assign word_ext  = WORD_BITS'(s_tdata);
    assign word_zero = (word_ext == '0);
    // odd parity over everything below the top bit
    assign parity    = ~^word_ext[WORD_BITS-2:0];
    assign send_ok   = (phase_reg == a429tx_pkg::PH_IDLE) && !word_zero;

    always_comb begin
        period = speed_high_reg ? high_ticks_reg : low_ticks_reg;
        if (period == '0) begin
            period = TW'(1);
        end
    end

    assign tick_inc = tick_count_reg + TW'(1);
    assign tick_end = (tick_inc >= period);
    assign last_bit = (bits_sent_reg == BITS_W'(WORD_BITS - 1));
    assign last_gap = ((gap_reg + GAP_W'(1)) == GAP_W'(GAP_PERIODS));

    // ---------------- next state ----------------
    always_comb begin
        phase_next      = phase_reg;
        shift_next      = shift_reg;
        bits_sent_next  = bits_sent_reg;
        tick_count_next = tick_count_reg;
        gap_next        = gap_reg;
        level_a_next    = level_a_reg;
        level_b_next    = level_b_reg;

        if (is_send) begin
            if (send_ok) begin
                shift_next      = {parity, word_ext[WORD_BITS-2:0]};
                bits_sent_next  = '0;
                tick_count_next = '0;
                gap_next        = '0;
                phase_next      = a429tx_pkg::PH_BITS;
                level_a_next    = word_ext[0];
                level_b_next    = ~word_ext[0];
            end
        end else if (is_tick) begin
            case (phase_reg)
                a429tx_pkg::PH_BITS: begin
                    tick_count_next = tick_inc;
                    if (tick_end) begin
                        tick_count_next = '0;
                        if (last_bit) begin
                            phase_next = a429tx_pkg::PH_GAP;
                            gap_next   = '0;
                        end else begin
                            // bit 0 of the shifter is always the bit on the line
                            bits_sent_next = bits_sent_reg + BITS_W'(1);
                            shift_next     = shift_reg >> 1;
                            level_a_next   = shift_reg[1];
                            level_b_next   = ~shift_reg[1];
                        end
                    end
                end
                a429tx_pkg::PH_GAP: begin
                    tick_count_next = tick_inc;
                    if (tick_end) begin
                        tick_count_next = '0;
                        gap_next        = gap_reg + GAP_W'(1);
                        if (last_gap) begin
                            phase_next     = a429tx_pkg::PH_IDLE;
                            gap_next       = '0;
                            bits_sent_next = '0;
                        end
                    end
                end
                default: phase_next = a429tx_pkg::PH_IDLE;
            endcase
        end
    end

    // ---------------- result ----------------
    always_comb begin
        result.line_a    = level_a_next;
        result.line_b    = level_b_next;
        result.busy_res  = (phase_next != a429tx_pkg::PH_IDLE);
        result.rejected  = is_send && !send_ok;
        result.word_done = is_tick && (phase_reg == a429tx_pkg::PH_GAP) && tick_end && last_gap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= a429tx_pkg::PH_IDLE;
            shift_reg      <= '0;
            bits_sent_reg  <= '0;
            tick_count_reg <= '0;
            gap_reg        <= '0;
            level_a_reg    <= 1'b0;
            level_b_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            shift_reg      <= shift_next;
            bits_sent_reg  <= bits_sent_next;
            tick_count_reg <= tick_count_next;
            gap_reg        <= gap_next;
            level_a_reg    <= level_a_next;
            level_b_reg    <= level_b_next;
        end
    end

    // ---------------- two-entry output buffer ----------------
    assign s_tready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= push;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_reg  <= skid_reg;
                skid_reg <= result;
            end else begin
                out_reg  <= result;
            end
        end else if (push) begin
            skid_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg};

    // ---------------- assertions ----------------
    // lines are always complementary while a word or its gap is on the line
    a_lines_differ: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != a429tx_pkg::PH_IDLE) |-> (level_a_reg != level_b_reg))
        else $error("line levels not complementary while busy");

    // the skid entry never holds a result while the main entry is empty
    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // a word_done result never reports busy
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.word_done) |-> !out_reg.busy_res)
        else $error("word_done reported while busy");

    // a rejected request leaves the transmit phase unchanged
    a_reject_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (is_send && !send_ok) |=> (phase_reg == $past(phase_reg)))
        else $error("rejected request changed the phase");

endmodule

`default_nettype wire
